/* rtl/core/ttst_pkg.sv */
package ttst_pkg;

   localparam int MAX_TASKS_DEF = 8;
   localparam int TIME_BITS_DEF = 16;
   localparam int MAX_RESULTS = 8;
   localparam int PEND_W = 8;
   localparam int IN_TIME_W = 16;
   localparam int IDX_W = 3;
   localparam int COUNT_W = 4;
   localparam int STATUS_W = 3;

   typedef enum logic [1:0] {
      REQ_ADD = 2'd0,
      REQ_TICK = 2'd1,
      REQ_DISPATCH = 2'd2,
      REQ_DELETE = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_ADDED = 3'd0,
      RSP_FULL = 3'd1,
      RSP_TICK_DONE = 3'd2,
      RSP_RUN = 3'd3,
      RSP_NONE_READY = 3'd4,
      RSP_DELETED = 3'd5,
      RSP_BAD_INDEX = 3'd6
   } status_type;

   typedef struct packed {
      logic load;
      logic tick;
      logic consume;
      logic shift;
      logic clear_ran;
   } cell_cmd_type;

   typedef struct packed {
      logic pend_nz;
      logic ran;
      logic one_shot;
   } cell_state_type;

endpackage

/* rtl/core/ttst_cell.sv */
module ttst_cell #(
   parameter int TIME_BITS = ttst_pkg::TIME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ttst_pkg::cell_cmd_type      cmd,
   input  logic [TIME_BITS-1:0]        ld_delay,
   input  logic [TIME_BITS-1:0]        ld_period,
   input  logic [TIME_BITS-1:0]        nxt_delay,
   input  logic [TIME_BITS-1:0]        nxt_period,
   input  logic [ttst_pkg::PEND_W-1:0] nxt_pending,
   input  logic                        nxt_ran,
   output logic [TIME_BITS-1:0]        cell_delay,
   output logic [TIME_BITS-1:0]        cell_period,
   output logic [ttst_pkg::PEND_W-1:0] cell_pending,
   output logic                        cell_ran,
   output ttst_pkg::cell_state_type    cell_st
);
   import ttst_pkg::*;

   logic [TIME_BITS-1:0] delay_ff, delay_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [PEND_W-1:0]    pending_ff, pending_in;
   logic                 ran_ff, ran_in;

   always_comb begin
      delay_in = delay_ff;
      period_in = period_ff;
      pending_in = pending_ff;
      if (cmd.load) begin
         delay_in = ld_delay;
         period_in = ld_period;
         pending_in = '0;
      end else if (cmd.tick) begin
         if (delay_ff != '0) begin
            delay_in = delay_ff - TIME_BITS'(1);
         end else begin
            delay_in = period_ff;
            if (pending_ff != {PEND_W{1'b1}}) begin
               pending_in = pending_ff + PEND_W'(1);
            end
         end
      end else if (cmd.consume) begin
         pending_in = pending_ff - PEND_W'(1);
      end else if (cmd.shift) begin
         // take the entry of the slot above
         delay_in = nxt_delay;
         period_in = nxt_period;
         pending_in = nxt_pending;
      end
   end

   always_comb begin
      ran_in = ran_ff;
      if (cmd.clear_ran) begin
         ran_in = 1'b0;
      end else if (cmd.consume) begin
         ran_in = 1'b1;
      end else if (cmd.shift) begin
         ran_in = nxt_ran;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff <= delay_in;
      period_ff <= period_in;
      pending_ff <= pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ran_ff <= 1'b0;
      end else begin
         ran_ff <= ran_in;
      end
   end

   assign cell_delay = delay_ff;
   assign cell_period = period_ff;
   assign cell_pending = pending_ff;
   assign cell_ran = ran_ff;
   assign cell_st.pend_nz = (pending_ff != '0);
   assign cell_st.ran = ran_ff;
   assign cell_st.one_shot = (period_ff == '0);

endmodule

/* rtl/core/ttst_ctrl.sv */
module ttst_ctrl #(
   parameter int MAX_TASKS = ttst_pkg::MAX_TASKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [ttst_pkg::IDX_W-1:0]    req_task_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ttst_pkg::STATUS_W-1:0] rsp_status,
   output logic [ttst_pkg::IDX_W-1:0]    rsp_task_id,
   output logic [ttst_pkg::COUNT_W-1:0]  rsp_task_count,
   output logic                          rsp_last,
   input  ttst_pkg::cell_state_type      cell_st [MAX_TASKS],
   output ttst_pkg::cell_cmd_type        cell_cmd [MAX_TASKS]
);
   import ttst_pkg::*;

   localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int RES_W = $clog2(MAX_RESULTS + 1);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_COMPACT
   } state_type;

   state_type            state_ff;
   logic [SLOT_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     kill_ff;
   logic [RES_W-1:0]     n_ff;
   logic [RES_W-1:0]     k_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [IDX_W-1:0]     rsp_task_id_ff;
   logic [COUNT_W-1:0]   rsp_task_count_ff;
   logic                 rsp_last_ff;

   req_kind_type         req_kind;
   cell_state_type       sel;
   logic                 out_free;
   logic                 acc;
   logic                 ptr_at_top;
   logic [CMP_W-1:0]     idx_ext;
   logic                 idx_ok;
   logic                 not_full;
   logic                 scan_take;
   logic                 emit_last;
   logic                 drop;
   logic [MAX_TASKS-1:0] load_vec;
   logic [MAX_TASKS-1:0] consume_vec;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign acc = req_valid && !req_stall;
   assign req_kind = req_kind_type'(req_type);
   assign sel = cell_st[ptr_ff];
   assign ptr_at_top = ((CNT_W'(ptr_ff) + CNT_W'(1)) == total_ff);
   assign idx_ext = CMP_W'(req_task_index);
   assign idx_ok = (idx_ext < CMP_W'(total_ff));
   assign not_full = (total_ff < CNT_W'(MAX_TASKS));
   // a pass reports at most MAX_RESULTS tasks, the rest keep their runs
   assign scan_take = (state_ff == ST_SCAN) && sel.pend_nz && (n_ff < RES_W'(MAX_RESULTS));
   assign emit_last = ((k_ff + RES_W'(1)) == n_ff);
   assign drop = (state_ff == ST_COMPACT) && sel.ran && sel.one_shot;

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         cell_cmd[i].load = acc && (req_kind == REQ_ADD) && not_full &&
                            (CNT_W'(i) == total_ff);
         cell_cmd[i].tick = acc && (req_kind == REQ_TICK);
         cell_cmd[i].clear_ran = acc && (req_kind == REQ_DISPATCH);
         cell_cmd[i].consume = scan_take && (SLOT_W'(i) == ptr_ff);
         // every slot at or above the removed one takes its upper neighbor
         cell_cmd[i].shift = (acc && (req_kind == REQ_DELETE) && idx_ok &&
                              (CMP_W'(i) >= idx_ext)) ||
                             (drop && (SLOT_W'(i) >= ptr_ff));
         load_vec[i] = cell_cmd[i].load;
         consume_vec[i] = cell_cmd[i].consume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff <= '0;
         total_ff <= '0;
         kill_ff <= '0;
         n_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  case (req_kind)
                     REQ_ADD: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_last_ff <= 1'b1;
                        if (not_full) begin
                           total_ff <= total_ff + CNT_W'(1);
                           rsp_status_ff <= RSP_ADDED;
                           rsp_task_id_ff <= IDX_W'(total_ff);
                           rsp_task_count_ff <= COUNT_W'(total_ff + CNT_W'(1));
                        end else begin
                           rsp_status_ff <= RSP_FULL;
                           rsp_task_id_ff <= '0;
                           rsp_task_count_ff <= COUNT_W'(total_ff);
                        end
                     end
                     REQ_TICK: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_last_ff <= 1'b1;
                        rsp_status_ff <= RSP_TICK_DONE;
                        rsp_task_id_ff <= '0;
                        rsp_task_count_ff <= COUNT_W'(total_ff);
                     end
                     REQ_DISPATCH: begin
                        if (total_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_last_ff <= 1'b1;
                           rsp_status_ff <= RSP_NONE_READY;
                           rsp_task_id_ff <= '0;
                           rsp_task_count_ff <= '0;
                        end else begin
                           state_ff <= ST_SCAN;
                           ptr_ff <= '0;
                           n_ff <= '0;
                           k_ff <= '0;
                           kill_ff <= '0;
                        end
                     end
                     REQ_DELETE: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_last_ff <= 1'b1;
                        rsp_task_id_ff <= req_task_index;
                        if (idx_ok) begin
                           total_ff <= total_ff - CNT_W'(1);
                           rsp_status_ff <= RSP_DELETED;
                           rsp_task_count_ff <= COUNT_W'(total_ff - CNT_W'(1));
                        end else begin
                           rsp_status_ff <= RSP_BAD_INDEX;
                           rsp_task_count_ff <= COUNT_W'(total_ff);
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // mark and consume first, so the count after compaction is known
               if (scan_take) begin
                  n_ff <= n_ff + RES_W'(1);
                  if (sel.one_shot) begin
                     kill_ff <= kill_ff + CNT_W'(1);
                  end
               end
               if (ptr_at_top) begin
                  state_ff <= ST_EMIT;
                  ptr_ff <= '0;
               end else begin
                  ptr_ff <= ptr_ff + SLOT_W'(1);
               end
            end
            ST_EMIT: begin
               if (n_ff == '0) begin
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_last_ff <= 1'b1;
                     rsp_status_ff <= RSP_NONE_READY;
                     rsp_task_id_ff <= '0;
                     rsp_task_count_ff <= COUNT_W'(total_ff);
                     state_ff <= ST_IDLE;
                  end
               end else if (sel.ran) begin
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_last_ff <= emit_last;
                     rsp_status_ff <= RSP_RUN;
                     rsp_task_id_ff <= IDX_W'(ptr_ff);
                     rsp_task_count_ff <= COUNT_W'(total_ff - kill_ff);
                     k_ff <= k_ff + RES_W'(1);
                     if (emit_last) begin
                        state_ff <= ST_COMPACT;
                        ptr_ff <= SLOT_W'(total_ff - CNT_W'(1));
                     end else begin
                        ptr_ff <= ptr_ff + SLOT_W'(1);
                     end
                  end
               end else begin
                  ptr_ff <= ptr_ff + SLOT_W'(1);
               end
            end
            ST_COMPACT: begin
               // top down, so slots still to visit keep their place
               if (drop) begin
                  total_ff <= total_ff - CNT_W'(1);
               end
               if (ptr_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  ptr_ff <= ptr_ff - SLOT_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_task_id = rsp_task_id_ff;
   assign rsp_task_count = rsp_task_count_ff;
   assign rsp_last = rsp_last_ff;

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_TASKS))
      else $error("task count beyond table size");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_vec))
      else $error("more than one slot loaded");

   a_single_consume: assert property (@(posedge clock) disable iff (reset)
      $onehot0(consume_vec))
      else $error("more than one slot consumed");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((n_ff == '0) || (k_ff < n_ff)))
      else $error("more runs reported than marked");

   a_dispatch_start: assert property (@(posedge clock) disable iff (reset)
      (acc && (req_kind == REQ_DISPATCH) && (total_ff != '0)) |=> (state_ff == ST_SCAN))
      else $error("dispatch pass did not start");

endmodule

/* rtl/core/tick_task_scheduler_table.sv */
// add, tick and delete: one transfer per cycle unless the output stalls; result registered
// dispatch pass: a scan marks and consumes runs, a report walk emits the ran tasks
// (held by output stalls), a compaction removes ran one-shot tasks; one request at a time
// the task table is a chain of per-slot cells; removal shifts the upper cells down one slot
// synchronous reset empties the table and clears the sequencer and output valid;
// task times and run counts are not cleared and hold garbage until written by an add
module tick_task_scheduler_table #(
   parameter int MAX_TASKS = ttst_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = ttst_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic [ttst_pkg::IN_TIME_W-1:0] req_delay,
   input  logic [ttst_pkg::IN_TIME_W-1:0] req_period,
   input  logic [ttst_pkg::IDX_W-1:0]     req_task_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ttst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ttst_pkg::IDX_W-1:0]     rsp_task_id,
   output logic [ttst_pkg::COUNT_W-1:0]   rsp_task_count,
   output logic                           rsp_last
);
   import ttst_pkg::*;

   cell_state_type       cell_st [MAX_TASKS];
   cell_cmd_type         cell_cmd [MAX_TASKS];
   logic [TIME_BITS-1:0] c_delay [MAX_TASKS];
   logic [TIME_BITS-1:0] c_period [MAX_TASKS];
   logic [PEND_W-1:0]    c_pending [MAX_TASKS];
   logic                 c_ran [MAX_TASKS];
   logic [TIME_BITS-1:0] ld_delay;
   logic [TIME_BITS-1:0] ld_period;

   assign ld_delay = TIME_BITS'(req_delay);
   assign ld_period = TIME_BITS'(req_period);

   ttst_ctrl #(
      .MAX_TASKS(MAX_TASKS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_task_index(req_task_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_task_id(rsp_task_id),
      .rsp_task_count(rsp_task_count),
      .rsp_last(rsp_last),
      .cell_st(cell_st),
      .cell_cmd(cell_cmd)
   );

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      logic [TIME_BITS-1:0] up_delay;
      logic [TIME_BITS-1:0] up_period;
      logic [PEND_W-1:0]    up_pending;
      logic                 up_ran;

      // top cell has no neighbor above and keeps its own entry
      if (i == MAX_TASKS - 1) begin : g_top
         assign up_delay = c_delay[i];
         assign up_period = c_period[i];
         assign up_pending = c_pending[i];
         assign up_ran = c_ran[i];
      end else begin : g_mid
         assign up_delay = c_delay[i+1];
         assign up_period = c_period[i+1];
         assign up_pending = c_pending[i+1];
         assign up_ran = c_ran[i+1];
      end

      ttst_cell #(
         .TIME_BITS(TIME_BITS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cell_cmd[i]),
         .ld_delay(ld_delay),
         .ld_period(ld_period),
         .nxt_delay(up_delay),
         .nxt_period(up_period),
         .nxt_pending(up_pending),
         .nxt_ran(up_ran),
         .cell_delay(c_delay[i]),
         .cell_period(c_period[i]),
         .cell_pending(c_pending[i]),
         .cell_ran(c_ran[i]),
         .cell_st(cell_st[i])
      );
   end

endmodule

/* test/tick_task_scheduler_table_tb.sv */
`timescale 1ns / 100ps

module tick_task_scheduler_table_tb;
   import ttst_pkg::*;

   localparam int SLOTS = MAX_TASKS_DEF;
   localparam int CLK_HALF = 6;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int REPORT_MAX = 10;

   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] task_id;
      logic [COUNT_W-1:0] task_count;
      logic             last;
   } sched_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_type;
   logic [IN_TIME_W-1:0] req_delay;
   logic [IN_TIME_W-1:0] req_period;
   logic [IDX_W-1:0]     req_task_index;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [IDX_W-1:0]     rsp_task_id;
   logic [COUNT_W-1:0]   rsp_task_count;
   logic                 rsp_last;

   // scheduler table as the testbench sees it
   logic [IN_TIME_W-1:0] tbl_delay [SLOTS];
   logic [IN_TIME_W-1:0] tbl_period [SLOTS];
   logic [PEND_W-1:0]    tbl_runs [SLOTS];
   int                   tbl_total;

   sched_result_type sched_result_q[$];
   int            mismatch_count;
   int            burst_left;
   int            hold_cycles;

   tick_task_scheduler_table u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_delay      (req_delay),
      .req_period     (req_period),
      .req_task_index (req_task_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_task_id    (rsp_task_id),
      .rsp_task_count (rsp_task_count),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic void push_result(status_type st, int id, logic last);
      sched_result_type r;
      r.status = st;
      r.task_id = IDX_W'(id);
      r.task_count = COUNT_W'(tbl_total);
      r.last = last;
      sched_result_q.push_back(r);
   endfunction

   function automatic void drop_slot(int slot);
      int i;
      for (i = slot; i + 1 < tbl_total; i++) begin
         tbl_delay[i] = tbl_delay[i+1];
         tbl_period[i] = tbl_period[i+1];
         tbl_runs[i] = tbl_runs[i+1];
      end
      tbl_total--;
   endfunction

   // update the table for one accepted request and queue its results
   function automatic void apply_request(req_kind_type kind, logic [IN_TIME_W-1:0] dly,
                                         logic [IN_TIME_W-1:0] per, logic [IDX_W-1:0] idx);
      logic ran [SLOTS];
      int   ids [MAX_RESULTS];
      int   n;
      int   i;
      int   slot;
      n = 0;
      for (i = 0; i < SLOTS; i++) ran[i] = 1'b0;
      case (kind)
         REQ_ADD: begin
            if (tbl_total < SLOTS) begin
               slot = tbl_total;
               tbl_delay[slot] = dly;
               tbl_period[slot] = per;
               tbl_runs[slot] = '0;
               tbl_total++;
               push_result(RSP_ADDED, slot, 1'b1);
            end else begin
               push_result(RSP_FULL, 0, 1'b1);
            end
         end
         REQ_TICK: begin
            for (i = 0; i < tbl_total; i++) begin
               if (tbl_delay[i] != 0) begin
                  tbl_delay[i]--;
               end else begin
                  tbl_delay[i] = tbl_period[i];
                  if (tbl_runs[i] != '1) tbl_runs[i]++;
               end
            end
            push_result(RSP_TICK_DONE, 0, 1'b1);
         end
         REQ_DISPATCH: begin
            for (i = 0; i < tbl_total && n < MAX_RESULTS; i++) begin
               if (tbl_runs[i] != 0) begin
                  tbl_runs[i]--;
                  ran[i] = 1'b1;
                  ids[n] = i;
                  n++;
               end
            end
            // one-shot tasks that ran leave the table, top slot first
            for (i = tbl_total - 1; i >= 0; i--) begin
               if (ran[i] && tbl_period[i] == 0) drop_slot(i);
            end
            if (n == 0) begin
               push_result(RSP_NONE_READY, 0, 1'b1);
            end else begin
               for (i = 0; i < n; i++) push_result(RSP_RUN, ids[i], i == n - 1);
            end
         end
         default: begin
            if (idx < tbl_total) begin
               drop_slot(idx);
               push_result(RSP_DELETED, idx, 1'b1);
            end else begin
               push_result(RSP_BAD_INDEX, idx, 1'b1);
            end
         end
      endcase
   endfunction

   // offer one request, in bursts with random gaps, and wait for its transfer
   task automatic send_request(req_kind_type kind, logic [IN_TIME_W-1:0] dly,
                               logic [IN_TIME_W-1:0] per, logic [IDX_W-1:0] idx);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= kind;
      req_delay <= dly;
      req_period <= per;
      req_task_index <= idx;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_request(kind, dly, per, idx);
   endtask

   task automatic send_random_request();
      int                   pick;
      req_kind_type         kind;
      logic [IN_TIME_W-1:0] dly;
      logic [IN_TIME_W-1:0] per;
      logic [IDX_W-1:0]     idx;
      pick = $urandom_range(0, 99);
      if (pick < ((tbl_total < 3) ? 45 : 30)) kind = REQ_ADD;
      else if (pick < 65) kind = REQ_TICK;
      else if (pick < 85) kind = REQ_DISPATCH;
      else kind = REQ_DELETE;
      dly = IN_TIME_W'($urandom);
      per = IN_TIME_W'($urandom);
      idx = IDX_W'($urandom_range(0, SLOTS - 1));
      if (kind == REQ_ADD) begin
         // mostly short times so that tasks actually fire
         if ($urandom_range(0, 9) < 7) dly = IN_TIME_W'($urandom_range(0, 3));
         pick = $urandom_range(0, 9);
         if (pick < 3) per = '0;
         else if (pick < 8) per = IN_TIME_W'($urandom_range(1, 4));
      end
      if (kind == REQ_DELETE && tbl_total > 0 && $urandom_range(0, 4) != 0)
         idx = IDX_W'($urandom_range(0, tbl_total - 1));
      send_request(kind, dly, per, idx);
   endtask

   // let the table go quiet: no request offered, every result back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sched_result_q.size() != 0) @(posedge clock);
   endtask

   task automatic clear_table();
      while (tbl_total > 0) send_request(REQ_DELETE, '0, '0, '0);
   endtask

   task automatic test_directed();
      send_request(REQ_DISPATCH, '0, '0, '0);
      send_request(REQ_DELETE, '0, '0, '0);
      send_request(REQ_TICK, '1, '1, '1);
      send_request(REQ_ADD, '0, '0, '0);
      send_request(REQ_ADD, '1, '1, '1);
      send_request(REQ_ADD, 16'd1, 16'd2, '0);
      send_request(REQ_ADD, 16'd0, 16'd3, '0);
      send_request(REQ_ADD, 16'd2, 16'd0, '0);
      send_request(REQ_ADD, 16'd0, 16'd1, '0);
      send_request(REQ_ADD, 16'd3, 16'd5, '0);
      send_request(REQ_ADD, 16'h5555, 16'hAAAA, '0);
      send_request(REQ_ADD, 16'd7, 16'd7, '0);
      send_request(REQ_TICK, '0, '0, '0);
      send_request(REQ_TICK, '0, '0, '0);
      send_request(REQ_DISPATCH, '0, '0, '0);
      send_request(REQ_DELETE, '0, '0, 3'd7);
      send_request(REQ_DELETE, '0, '0, 3'd1);
      send_request(REQ_TICK, '0, '0, '0);
      send_request(REQ_TICK, '0, '0, '0);
      send_request(REQ_DISPATCH, '0, '0, '0);
      send_request(REQ_DISPATCH, '0, '0, '0);
      send_request(REQ_DELETE, '0, '0, 3'd0);
   endtask

   // every slot ready at once, a few of them one-shot
   task automatic test_full_pass();
      int i;
      clear_table();
      for (i = 0; i < SLOTS; i++)
         send_request(REQ_ADD, '0, (i % 3 == 0) ? '0 : IN_TIME_W'($urandom_range(1, 65535)),
                      '0);
      send_request(REQ_TICK, '0, '0, '0);
      send_request(REQ_DISPATCH, '0, '0, '0);
      send_request(REQ_DISPATCH, '0, '0, '0);
   endtask

   task automatic test_backpressure();
      int i;
      drain_results();
      hold_cycles = 80;
      burst_left = 40;
      for (i = 0; i < 30; i++) send_random_request();
      drain_results();
   endtask

   task automatic test_random();
      int i;
      for (i = 0; i < 90; i++) send_random_request();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_ADD;
      req_delay <= '0;
      req_period <= '0;
      req_task_index <= '0;
      tbl_total = 0;
      mismatch_count = 0;
      burst_left = 0;
      hold_cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_pass();
      test_backpressure();
      test_random();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && sched_result_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // receiver stall: segments of differing density, plus a long hold-off during the backpressure test
   initial begin
      int seg_len;
      int mode;
      rsp_stall <= 1'b0;
      forever begin
         seg_len = $urandom_range(5, 40);
         mode = $urandom_range(0, 3);
         repeat (seg_len) begin
            @(posedge clock);
            if (hold_cycles > 0) begin
               rsp_stall <= 1'b1;
               hold_cycles--;
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 2) == 0);
                  2: rsp_stall <= ~rsp_stall;
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   // result check against the oldest queued result
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (sched_result_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result transfer: status %0d id %0d count %0d last %0d",
                        rsp_status, rsp_task_id, rsp_task_count, rsp_last);
         end else begin
            want = sched_result_q.pop_front();
            if (rsp_status !== want.status || rsp_task_id !== want.task_id ||
                rsp_task_count !== want.task_count || rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("result mismatch at %0t: status %0d/%0d id %0d/%0d",
                           $realtime, want.status, rsp_status, want.task_id, rsp_task_id,
                           " count %0d/%0d last %0d/%0d (exp/got)",
                           want.task_count, rsp_task_count, want.last, rsp_last);
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule
